// ----- rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants, codes and types of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // cache geometry
  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OUR_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUR_MAC = 1'd1;

  // item kinds
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_HW    = 3'd2;
  localparam logic [2:0] ST_BAD_PROTO = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  // packet field values
  localparam logic [15:0] MIN_PKT_LEN    = 16'd28;
  localparam logic [15:0] HW_ETHER       = 16'd1;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OPER_REQUEST   = 16'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pkt_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] operation;
    logic [47:0] hardware_addr;
    logic [31:0] protocol_addr;
    logic [31:0] target_addr;
  } arpc_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        reply_valid;
    logic [47:0] reply_dest_mac;
    logic [31:0] reply_dest_ip;
  } arpc_result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic write;
  } arpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       pkt_ok;
    logic       hit;
    logic       scan_end;
  } arpc_sts_t;

endpackage

// ----- rtl/arpc_if.sv -----
// ----------------------------------------------------------------------------
// arpc channel interfaces
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] pkt_len;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_len;
  logic [7:0]  proto_len;
  logic [15:0] operation;
  logic [47:0] hardware_addr;
  logic [31:0] protocol_addr;
  logic [31:0] target_addr;

  modport source (
    output valid, op, pkt_len, hw_type, proto_type, hw_len, proto_len,
           operation, hardware_addr, protocol_addr, target_addr,
    input  ready
  );
  modport sink (
    input  valid, op, pkt_len, hw_type, proto_type, hw_len, proto_len,
           operation, hardware_addr, protocol_addr, target_addr,
    output ready
  );
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        lookup_hit;
  logic [47:0] lookup_mac;
  logic        reply_valid;
  logic [47:0] reply_dest_mac;
  logic [31:0] reply_dest_ip;

  modport source (
    output valid, status, lookup_hit, lookup_mac, reply_valid, reply_dest_mac,
           reply_dest_ip,
    input  ready
  );
  modport sink (
    input  valid, status, lookup_hit, lookup_mac, reply_valid, reply_dest_mac,
           reply_dest_ip,
    output ready
  );
endinterface

// ----- rtl/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: accept, check, scan the cache, write back, present result.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output arpc_pkg::arpc_cmd_t cmd,
  input  arpc_pkg::arpc_sts_t sts
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_t;

  state_t state;

  // handshakes follow the state
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);

  // datapath commands
  always_comb begin
    cmd       = '0;
    cmd.load  = (state == S_IDLE) && req_valid;
    cmd.check = (state == S_CHECK);
    cmd.scan  = (state == S_SCAN);
    cmd.write = (state == S_WRITE);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.op == OP_NONE || (sts.op == OP_PACKET && !sts.pkt_ok)) begin
            state <= S_RESP;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.hit || sts.scan_end) begin
            state <= (sts.op == OP_LOOKUP) ? S_RESP : S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/arpc_dp.sv -----
// ----------------------------------------------------------------------------
// arpc_dp
// Request registers, packet checks, cache memory with scan and write-back,
// replacement pointer, configuration registers and result register.
// ----------------------------------------------------------------------------
module arpc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  arpc_pkg::arpc_item_t                item_in,
  input  arpc_pkg::arpc_cmd_t                 cmd,
  output arpc_pkg::arpc_sts_t                 sts,
  output arpc_pkg::arpc_result_t              result
);
  import arpc_pkg::*;

  // configuration
  logic [31:0] our_ip;
  logic [47:0] our_mac;

  // held request
  arpc_item_t item;

  // cache storage
  logic [31:0]        mem_ip  [CACHE_ENTRIES];
  logic [47:0]        mem_mac [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]   replace_slot;

  // scan pipeline
  logic [IDX_W:0]     scan_addr;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [31:0]        rd_ip;
  logic [47:0]        rd_mac;
  logic               found;
  logic [IDX_W-1:0]   match_idx;
  logic               hit_now;
  logic [IDX_W-1:0]   wr_addr;

  // result fields
  logic [2:0]  status;
  logic        lookup_hit;
  logic [47:0] lookup_mac;
  logic        reply_valid;
  logic [47:0] reply_dest_mac;
  logic [31:0] reply_dest_ip;

  logic [2:0]  chk_status;
  logic        reply_due;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      our_ip  <= '0;
      our_mac <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUR_IP:  our_ip  <= cfg_data[31:0];
        CFG_OUR_MAC: our_mac <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // packet checks, first failure wins
  always_comb begin
    priority if (item.pkt_len < MIN_PKT_LEN) begin
      chk_status = ST_TOO_SHORT;
    end else if (item.hw_type != HW_ETHER) begin
      chk_status = ST_BAD_HW;
    end else if (item.proto_type != PROTO_IPV4) begin
      chk_status = ST_BAD_PROTO;
    end else if (item.hw_len != HW_ADDR_LEN || item.proto_len != PROTO_ADDR_LEN) begin
      chk_status = ST_BAD_LEN;
    end else begin
      chk_status = ST_DONE;
    end
  end

  assign reply_due = (item.op == OP_PACKET) && (chk_status == ST_DONE) &&
                     (item.operation == OPER_REQUEST) && (item.target_addr == our_ip);

  // compare stage of the scan
  assign hit_now = rd_vld && entry_valid[rd_idx] && (rd_ip == item.protocol_addr);

  always_comb begin
    sts          = '0;
    sts.op       = item.op;
    sts.pkt_ok   = (chk_status == ST_DONE);
    sts.hit      = hit_now;
    sts.scan_end = rd_vld && (rd_idx == IDX_W'(CACHE_ENTRIES - 1));
  end

  // update an existing entry or take the round-robin slot
  assign wr_addr = found ? match_idx : replace_slot;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) item <= item_in;
  end

  // cache memory: one read per scan cycle, one write on write-back
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_ip  <= mem_ip[scan_addr[IDX_W-1:0]];
      rd_mac <= mem_mac[scan_addr[IDX_W-1:0]];
      rd_idx <= scan_addr[IDX_W-1:0];
    end
    if (cmd.write) begin
      mem_ip[wr_addr]  <= item.protocol_addr;
      mem_mac[wr_addr] <= item.hardware_addr;
    end
  end

  // scan control, valid bits and replacement pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr    <= '0;
      rd_vld       <= 1'b0;
      found        <= 1'b0;
      entry_valid  <= '0;
      replace_slot <= '0;
    end else begin
      if (cmd.load) begin
        scan_addr <= '0;
        rd_vld    <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= (scan_addr < (IDX_W+1)'(CACHE_ENTRIES));
        if (scan_addr < (IDX_W+1)'(CACHE_ENTRIES)) scan_addr <= scan_addr + 1'b1;
        if (hit_now) found <= 1'b1;
      end
      if (cmd.write) begin
        entry_valid[wr_addr] <= 1'b1;
        if (!found) begin
          if (replace_slot == IDX_W'(CACHE_ENTRIES - 1)) begin
            replace_slot <= '0;
          end else begin
            replace_slot <= replace_slot + 1'b1;
          end
        end
      end
    end
  end

  // matched slot
  always_ff @(posedge clk) begin
    if (cmd.scan && hit_now) match_idx <= rd_idx;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status         <= ST_DONE;
      lookup_hit     <= 1'b0;
      lookup_mac     <= '0;
      reply_valid    <= 1'b0;
      reply_dest_mac <= '0;
      reply_dest_ip  <= '0;
    end else begin
      if (cmd.check) begin
        status         <= (item.op == OP_PACKET) ? chk_status : ST_DONE;
        reply_valid    <= reply_due;
        reply_dest_mac <= reply_due ? item.hardware_addr : '0;
        reply_dest_ip  <= reply_due ? item.protocol_addr : '0;
      end
      if (cmd.scan && hit_now && item.op == OP_LOOKUP) begin
        lookup_hit <= 1'b1;
        lookup_mac <= rd_mac;
      end
    end
  end

  always_comb begin
    result                = '0;
    result.status         = status;
    result.lookup_hit     = lookup_hit;
    result.lookup_mac     = lookup_mac;
    result.reply_valid    = reply_valid;
    result.reply_dest_mac = reply_dest_mac;
    result.reply_dest_ip  = reply_dest_ip;
  end

  // our_mac is held but not otherwise used in this block
  logic unused_mac;
  assign unused_mac = ^our_mac;

endmodule

// ----- rtl/arp_cache_and_responder_unit.sv -----
// ----------------------------------------------------------------------------
// arp_cache_and_responder_unit
// IPv4-to-MAC cache with round-robin replacement and ARP request detection.
//
// Channels: req carries one request (received packet, direct insert or
// lookup); rsp returns exactly one result per request. Both are valid/ready.
// cfg_we/cfg_index/cfg_data write our_ip (index 0) and our_mac (index 1);
// write only while no request is in flight.
// Timing: one request at a time. A request is accepted, then checked,
// then the cache memory is scanned at one entry per cycle, stopping
// at the first valid match or after the last entry; packets and inserts
// then get a write-back step, and the result then appears. A failed
// packet check or a request of kind OP_NONE goes straight to the result.
// The single cache read port sets the scan length.
// Reset: clears the valid bits, the replacement pointer and both registers;
// the cache contents are not cleared and no clearing pass is needed.
// Stall: the result is held on rsp until taken; req stays low meanwhile.
// ----------------------------------------------------------------------------
module arp_cache_and_responder_unit (
  input  logic                             clk,
  input  logic                             rst,
  arpc_req_if.sink                         req,
  arpc_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import arpc_pkg::*;

  arpc_item_t   item_in;
  arpc_result_t result;
  arpc_cmd_t    cmd;
  arpc_sts_t    sts;

  // pack the request payload
  always_comb begin
    item_in               = '0;
    item_in.op            = req.op;
    item_in.pkt_len       = req.pkt_len;
    item_in.hw_type       = req.hw_type;
    item_in.proto_type    = req.proto_type;
    item_in.hw_len        = req.hw_len;
    item_in.proto_len     = req.proto_len;
    item_in.operation     = req.operation;
    item_in.hardware_addr = req.hardware_addr;
    item_in.protocol_addr = req.protocol_addr;
    item_in.target_addr   = req.target_addr;
  end

  // controller
  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  arpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_in   (item_in),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  // result payload
  assign rsp.status         = result.status;
  assign rsp.lookup_hit     = result.lookup_hit;
  assign rsp.lookup_mac     = result.lookup_mac;
  assign rsp.reply_valid    = result.reply_valid;
  assign rsp.reply_dest_mac = result.reply_dest_mac;
  assign rsp.reply_dest_ip  = result.reply_dest_ip;

endmodule
